// ===== sv/cmr_pkg.sv =====
// Shared types and constants of the CAN multiframe reassembler.
package cmr_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 64;

    localparam int ID_W       = 29;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 64;
    localparam int SIZE_W     = 12;
    localparam int TMO_W      = 16;
    localparam int BYTE_IDX_W = 6;
    localparam int MSG_LEN_W  = 7;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [3:0] FT_SINGLE = 4'd0;
    localparam logic [3:0] FT_FIRST  = 4'd1;
    localparam logic [3:0] FT_CONSEC = 4'd2;

    localparam logic [3:0] SINGLE_MAX   = 4'd7;
    localparam logic [2:0] CONSEC_BYTES = 3'd7;
    localparam logic [2:0] FIRST_BYTES  = 3'd6;

    typedef enum logic [1:0] {
        OP_SINGLE,
        OP_FIRST,
        OP_CONSEC,
        OP_DROP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [DATA_W-1:0]  data;
        logic [SIZE_W-1:0]  size;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_SINGLE
    } t_back_state;

endpackage

// ===== sv/cmr_if.sv =====
// Channel interfaces of the CAN multiframe reassembler: frames, configuration, bytes.
interface cmr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [cmr_pkg::ID_W-1:0]      frame_id;
    logic [cmr_pkg::LEN_W-1:0]     frame_len;
    logic [cmr_pkg::DATA_W-1:0]    frame_data;

    modport source (output valid, kind, frame_id, frame_len, frame_data, input ready);
    modport sink   (input valid, kind, frame_id, frame_len, frame_data, output ready);
endinterface

interface cmr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cmr_pkg::TMO_W-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

interface cmr_out_if;
    logic                             valid;
    logic                             ready;
    logic [cmr_pkg::ID_W-1:0]         msg_id;
    logic [7:0]                       data_byte;
    logic [cmr_pkg::BYTE_IDX_W-1:0]   byte_index;
    logic [cmr_pkg::MSG_LEN_W-1:0]    msg_length;
    logic                             is_last;

    modport source (output valid, msg_id, data_byte, byte_index, msg_length, is_last,
                    input ready);
    modport sink   (input valid, msg_id, data_byte, byte_index, msg_length, is_last,
                    output ready);
endinterface

// ===== sv/can_multiframe_reassembler.sv =====
// Top level of the CAN multiframe reassembler: front end, command queue, back end.
//
// Usage: i_frame carries received CAN frames (kind 0) and time ticks (kind 1) with a
// valid/ready handshake. o_msg delivers reassembled messages one byte per transaction,
// in order, with byte_index, msg_length, msg_id and is_last on the final byte.
// i_cfg writes timeout_ticks; it is always ready and should only be written while idle.
// Order: a single frame passes the command queue, the back end's pop, the read stage
// and the output register; a completing consecutive frame first writes its bytes into
// the store (one byte per cycle, up to seven), then the message drains through the read
// stage and the output register at one byte per cycle while the receiver is ready.
// Throughput: the front end accepts one item per cycle while the four-entry command
// queue has room; the back end pops a command and writes or delivers all its bytes
// before it pops the next, set by the single write/read port of the message store.
// Reset clears the reception, the idle counter and the queue, and loads a timeout of
// 1000 ticks. The store is not cleared; every byte read from the store is written first.
// When the receiver stalls, the output register and a one-entry read stage hold bytes,
// the back end waits, and the queue fills before i_frame.ready drops.
module can_multiframe_reassembler #(
    parameter int MAX_MESSAGE_BYTES = cmr_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cmr_in_if.sink      i_frame,
    cmr_cfg_if.sink     i_cfg,
    cmr_out_if.source   o_msg
);

    cmr_pkg::t_cmd push_cmd;
    cmr_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    cmr_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (i_frame),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    cmr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    cmr_back #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_msg   (o_msg)
    );

endmodule

// ===== sv/cmr_front.sv =====
// Front end: accepts frames and ticks, tracks idle time and classifies into commands.
module cmr_front #(
    parameter int MAX_MESSAGE_BYTES = cmr_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cmr_in_if.sink          i_frame,
    cmr_cfg_if.sink         i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output cmr_pkg::t_cmd   o_cmd
);

    localparam int SW = cmr_pkg::SIZE_W;
    localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_MESSAGE_BYTES);
    localparam logic [SW-1:0] MIN_SIZE = SW'(8);

    logic [cmr_pkg::TMO_W-1:0] r_timeout;
    logic [cmr_pkg::TMO_W-1:0] r_idle;
    logic [cmr_pkg::TMO_W-1:0] n_idle;
    logic [7:0]                b0;
    logic [3:0]                sgl_size;
    logic [SW-1:0]             ff_size;
    logic                      accept;
    logic                      want_push;

    assign i_frame.ready = !i_full;
    assign i_cfg.ready   = 1'b1;
    assign accept        = i_frame.valid && !i_full;
    assign o_push        = accept && want_push;

    assign b0       = i_frame.frame_data[7:0];
    assign sgl_size = b0[3:0];
    assign ff_size  = {b0[3:0], i_frame.frame_data[15:8]};

    always_comb begin
        n_idle = (r_idle == '1) ? r_idle : r_idle + 16'd1;
        want_push   = 1'b0;
        o_cmd.op    = cmr_pkg::OP_DROP;
        o_cmd.id    = i_frame.frame_id;
        o_cmd.data  = i_frame.frame_data;
        o_cmd.size  = ff_size;
        if (i_frame.kind == cmr_pkg::KIND_TICK) begin
            // A drop is issued on every tick past the timeout; dropping is idempotent.
            want_push = (n_idle > r_timeout);
        end else begin
            case (b0[7:4])
                cmr_pkg::FT_SINGLE: begin
                    want_push  = (sgl_size != 4'd0) && (sgl_size <= cmr_pkg::SINGLE_MAX)
                                 && ((sgl_size + 4'd1) == i_frame.frame_len);
                    o_cmd.op   = cmr_pkg::OP_SINGLE;
                    o_cmd.size = SW'(sgl_size);
                end
                cmr_pkg::FT_FIRST: begin
                    want_push = 1'b1;
                    o_cmd.op  = (ff_size >= MIN_SIZE && ff_size <= MAX_SIZE)
                                ? cmr_pkg::OP_FIRST : cmr_pkg::OP_DROP;
                end
                cmr_pkg::FT_CONSEC: begin
                    want_push = 1'b1;
                    o_cmd.op  = cmr_pkg::OP_CONSEC;
                end
                default: begin
                    want_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle    <= '0;
            r_timeout <= cmr_pkg::TIMEOUT_RESET;
        end else begin
            if (accept) begin
                r_idle <= (i_frame.kind == cmr_pkg::KIND_TICK) ? n_idle : '0;
            end
            if (i_cfg.valid) begin
                r_timeout <= i_cfg.data;
            end
        end
    end

endmodule

// ===== sv/cmr_fifo.sv =====
// Short command queue between the front end and the back end.
module cmr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmr_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output cmr_pkg::t_cmd   o_head,
    output logic            o_full,
    output logic            o_empty
);

    localparam int AW = cmr_pkg::QUEUE_AW;

    cmr_pkg::t_cmd r_mem [cmr_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(cmr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/cmr_back.sv =====
// Back end: executes commands, holds the message store and streams bytes out.
module cmr_back #(
    parameter int MAX_MESSAGE_BYTES = cmr_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cmr_pkg::t_cmd   i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    cmr_out_if.source       o_msg
);

    localparam int LW = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int AW = $clog2(MAX_MESSAGE_BYTES);

    cmr_pkg::t_back_state r_state;
    cmr_pkg::t_back_state n_state;

    logic [7:0]                   r_mem [MAX_MESSAGE_BYTES];
    logic [LW-1:0]                r_exp;
    logic [LW-1:0]                r_rcv;
    logic [cmr_pkg::DATA_W-1:0]   r_data;
    logic [cmr_pkg::ID_W-1:0]     r_id;
    logic [2:0]                   r_left;
    logic [AW-1:0]                r_wptr;
    logic                         r_complete;
    logic [LW-1:0]                r_rptr;
    logic [LW-1:0]                r_total;

    // Read stage: holds one byte between the store read or single-frame data and the output register.
    logic                         r_rd_valid;
    logic [7:0]                   r_rd_byte;
    logic [cmr_pkg::BYTE_IDX_W-1:0] r_rd_idx;
    logic [cmr_pkg::MSG_LEN_W-1:0]  r_rd_len;
    logic                         r_rd_last;
    logic [cmr_pkg::ID_W-1:0]     r_rd_id;

    logic                         r_out_valid;
    logic [7:0]                   r_out_byte;
    logic [cmr_pkg::BYTE_IDX_W-1:0] r_out_idx;
    logic [cmr_pkg::MSG_LEN_W-1:0]  r_out_len;
    logic                         r_out_last;
    logic [cmr_pkg::ID_W-1:0]     r_out_id;

    logic          rcv_open;
    logic [LW-1:0] remain;
    logic          cons_complete;
    logic [2:0]    take;
    logic [LW-1:0] rptr_inc;
    logic          last_issue;
    logic          out_free;
    logic          move;
    logic          rd_free;
    logic          issue;
    logic          mem_we;

    assign rcv_open      = (r_exp != '0) && (r_rcv < r_exp);
    assign remain        = r_exp - r_rcv;
    assign cons_complete = (remain <= LW'(cmr_pkg::CONSEC_BYTES));
    assign take          = cons_complete ? remain[2:0] : cmr_pkg::CONSEC_BYTES;
    assign rptr_inc      = r_rptr + LW'(1);
    assign last_issue    = (rptr_inc == r_total);

    assign out_free = !r_out_valid || o_msg.ready;
    assign move     = r_rd_valid && out_free;
    assign rd_free  = !r_rd_valid || move;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cmr_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.op)
                        cmr_pkg::OP_SINGLE: n_state = cmr_pkg::ST_SINGLE;
                        cmr_pkg::OP_FIRST:  n_state = cmr_pkg::ST_WRITE;
                        cmr_pkg::OP_CONSEC: n_state = rcv_open ? cmr_pkg::ST_WRITE
                                                               : cmr_pkg::ST_IDLE;
                        default:            n_state = cmr_pkg::ST_IDLE;
                    endcase
                end
            end
            cmr_pkg::ST_WRITE: begin
                if (r_left == 3'd1) begin
                    n_state = r_complete ? cmr_pkg::ST_READ : cmr_pkg::ST_IDLE;
                end
            end
            cmr_pkg::ST_READ, cmr_pkg::ST_SINGLE: begin
                if (issue && last_issue) begin
                    n_state = cmr_pkg::ST_IDLE;
                end
            end
            default: n_state = cmr_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop  = 1'b0;
        mem_we = 1'b0;
        issue  = 1'b0;
        case (r_state)
            cmr_pkg::ST_IDLE:   o_pop  = !i_empty;
            cmr_pkg::ST_WRITE:  mem_we = 1'b1;
            cmr_pkg::ST_READ:   issue  = rd_free;
            cmr_pkg::ST_SINGLE: issue  = rd_free;
            default:            o_pop  = 1'b0;
        endcase
    end

    // Message store and its registered read port; single frames bypass the store.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wptr] <= r_data[7:0];
        end
        if (issue) begin
            r_rd_byte <= (r_state == cmr_pkg::ST_READ) ? r_mem[r_rptr[AW-1:0]]
                                                        : r_data[7:0];
            r_rd_idx  <= cmr_pkg::BYTE_IDX_W'(r_rptr);
            r_rd_len  <= cmr_pkg::MSG_LEN_W'(r_total);
            r_rd_last <= last_issue;
            r_rd_id   <= r_id;
        end
        if (move) begin
            r_out_byte <= r_rd_byte;
            r_out_idx  <= r_rd_idx;
            r_out_len  <= r_rd_len;
            r_out_last <= r_rd_last;
            r_out_id   <= r_rd_id;
        end
    end

    // Command execution datapath.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_id <= i_cmd.id;
            case (i_cmd.op)
                cmr_pkg::OP_SINGLE: begin
                    r_data  <= i_cmd.data >> 8;
                    r_rptr  <= '0;
                    r_total <= LW'(i_cmd.size[3:0]);
                end
                cmr_pkg::OP_FIRST: begin
                    r_data     <= i_cmd.data >> 16;
                    r_wptr     <= '0;
                    r_left     <= cmr_pkg::FIRST_BYTES;
                    r_complete <= 1'b0;
                end
                cmr_pkg::OP_CONSEC: begin
                    r_data     <= i_cmd.data >> 8;
                    r_wptr     <= r_rcv[AW-1:0];
                    r_left     <= take;
                    r_complete <= cons_complete;
                    r_rptr     <= '0;
                    r_total    <= r_exp;
                end
                default: begin
                    r_data <= i_cmd.data;
                end
            endcase
        end else if (mem_we) begin
            r_data <= r_data >> 8;
            r_wptr <= r_wptr + AW'(1);
            r_left <= r_left - 3'd1;
        end else if (issue) begin
            r_data <= r_data >> 8;
            r_rptr <= rptr_inc;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmr_pkg::ST_IDLE;
            r_exp       <= '0;
            r_rcv       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                case (i_cmd.op)
                    cmr_pkg::OP_FIRST: begin
                        r_exp <= i_cmd.size[LW-1:0];
                        r_rcv <= LW'(cmr_pkg::FIRST_BYTES);
                    end
                    cmr_pkg::OP_CONSEC: begin
                        if (rcv_open) begin
                            // On the completing frame the total is latched for the drain, so the reception closes.
                            r_exp <= cons_complete ? '0 : r_exp;
                            r_rcv <= cons_complete ? '0 : r_rcv + LW'(take);
                        end
                    end
                    default: begin
                        r_exp <= '0;
                        r_rcv <= '0;
                    end
                endcase
            end
            if (issue) begin
                r_rd_valid <= 1'b1;
            end else if (move) begin
                r_rd_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_msg.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_msg.valid      = r_out_valid;
    assign o_msg.data_byte  = r_out_byte;
    assign o_msg.byte_index = r_out_idx;
    assign o_msg.msg_length = r_out_len;
    assign o_msg.is_last    = r_out_last;
    assign o_msg.msg_id     = r_out_id;

endmodule
